// ===== rtl/rotated_sorted_array_search_defines.svh =====
// Assertion macros used by the rotated sorted array search back end.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define RSAS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsas assertion failed");
// Condition must never be true at a clock edge outside reset.
`define RSAS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rsas forbidden condition seen");
`else
`define RSAS_ASSERT(label, prop)
`define RSAS_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== rtl/rsas_pkg.sv =====
// Types and constants shared by the rotated sorted array search block.
package rsas_pkg;

  // Widths fixed by the item format.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 10;

  // Values of the kind field of an input beat.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Command queue between the front and the back.
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned CMD_PTR_W       = 1;
  localparam int unsigned CMD_CNT_W       = 2;

  // One input beat.
  typedef struct packed {
    logic                     kind;
    logic                     restart;
    logic signed [DATA_W-1:0] element;
    logic signed [DATA_W-1:0] target;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
  } out_item_t;

  // Command codes produced by the front.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RESTART,
    OP_SEARCH
  } op_e;

  // Classified command handed to the back.
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] operand;
  } cmd_t;

  // Command channel between the front and the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_REPLY
  } state_e;

endpackage

// ===== rtl/rsas_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module rsas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/rsas_front.sv =====
// Front end: accepts input beats, classifies them and queues the commands.
module rsas_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rsas_pkg::in_item_t in_item_i,
  output logic               full_o,
  output rsas_pkg::cmd_chan_t cmd_o,
  input  logic               cmd_pop_i
);

  rsas_pkg::cmd_t                       entry_q [rsas_pkg::CMD_QUEUE_DEPTH];
  logic [rsas_pkg::CMD_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rsas_pkg::CMD_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rsas_pkg::CMD_CNT_W-1:0]       cnt_q, cnt_d;
  rsas_pkg::cmd_t                       cmd_new;
  logic                                 do_push, do_pop;

  // Classify the incoming beat into a command.
  always_comb begin
    cmd_new.operand = in_item_i.target;
    case (in_item_i.kind)
      rsas_pkg::KIND_LOAD: begin
        cmd_new.operand = in_item_i.element;
        cmd_new.op      = in_item_i.restart ? rsas_pkg::OP_RESTART : rsas_pkg::OP_LOAD;
      end
      default: begin
        cmd_new.op = rsas_pkg::OP_SEARCH;
      end
    endcase
  end

  assign full_o  = (cnt_q == rsas_pkg::CMD_CNT_W'(rsas_pkg::CMD_QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && (cnt_q != '0);

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + (do_push ? rsas_pkg::CMD_PTR_W'(1) : '0);
    rd_ptr_d = rd_ptr_q + (do_pop ? rsas_pkg::CMD_PTR_W'(1) : '0);
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + rsas_pkg::CMD_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - rsas_pkg::CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/rsas_back.sv =====
// Back end: runs loads and rotated binary searches against the element store.
`include "rotated_sorted_array_search_defines.svh"

module rsas_back #(
  parameter int unsigned MaxElements = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsas_pkg::cmd_chan_t  cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output rsas_pkg::out_item_t  out_item_o
);

  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int unsigned CntW  = $clog2(MaxElements + 1);
  localparam int unsigned BndW  = CntW + 1;
  localparam logic signed [BndW-1:0] One = 1;

  rsas_pkg::state_e                    state_q, state_d;
  logic [CntW-1:0]                     count_q, count_d;
  logic signed [BndW-1:0]              low_q, low_d, high_q, high_d, mid_q, mid_d;
  logic signed [rsas_pkg::DATA_W-1:0]  target_q, target_d;
  rsas_pkg::out_item_t                 reply_q, reply_d;
  rsas_pkg::out_item_t                 out_q, out_d;
  logic                                out_valid_q, out_valid_d;

  logic                                we;
  logic [AddrW-1:0]                    waddr;
  logic signed [BndW-1:0]              mid_calc;
  logic [rsas_pkg::DATA_W-1:0]         rd_mid, rd_mid_copy, rd_low, rd_high;
  logic signed [rsas_pkg::DATA_W-1:0]  vm, vl, vh;
  logic [AddrW+rsas_pkg::INDEX_W-1:0]  mid_ext;

  // Midpoint of the current bounds; both are nonnegative while probing.
  assign mid_calc = low_q + ((high_q - low_q) >>> 1);

  // Two copies of the store: one reads the midpoint, the other both bounds.
  rsas_ram #(
    .WIDTH (rsas_pkg::DATA_W),
    .DEPTH (MaxElements),
    .AddrW (AddrW)
  ) u_ram_mid (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (cmd_i.cmd.operand),
    .raddr_a_i (mid_calc[AddrW-1:0]),
    .raddr_b_i (mid_calc[AddrW-1:0]),
    .rdata_a_o (rd_mid),
    .rdata_b_o (rd_mid_copy)
  );

  rsas_ram #(
    .WIDTH (rsas_pkg::DATA_W),
    .DEPTH (MaxElements),
    .AddrW (AddrW)
  ) u_ram_bnd (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (cmd_i.cmd.operand),
    .raddr_a_i (low_q[AddrW-1:0]),
    .raddr_b_i (high_q[AddrW-1:0]),
    .rdata_a_o (rd_low),
    .rdata_b_o (rd_high)
  );

  assign vm = $signed(rd_mid);
  assign vl = $signed(rd_low);
  assign vh = $signed(rd_high);

  assign mid_ext = {{rsas_pkg::INDEX_W{1'b0}}, mid_q[AddrW-1:0]};

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // Sequencer: next state, bound updates, store writes and result staging.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    target_d    = target_q;
    reply_d     = reply_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = count_q[AddrW-1:0];

    case (state_q)
      rsas_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.cmd.op)
            rsas_pkg::OP_RESTART: begin
              we      = 1'b1;
              waddr   = '0;
              count_d = CntW'(1);
            end
            rsas_pkg::OP_LOAD: begin
              if (count_q < CntW'(MaxElements)) begin
                we      = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            default: begin
              target_d      = cmd_i.cmd.operand;
              low_d         = '0;
              high_d        = $signed({1'b0, count_q}) - One;
              reply_d.found = 1'b0;
              reply_d.index = '0;
              state_d       = (count_q == '0) ? rsas_pkg::ST_REPLY : rsas_pkg::ST_PROBE;
            end
          endcase
        end
      end
      rsas_pkg::ST_PROBE: begin
        mid_d   = mid_calc;
        state_d = rsas_pkg::ST_CHECK;
      end
      rsas_pkg::ST_CHECK: begin
        if (vm == target_q) begin
          reply_d.found = 1'b1;
          reply_d.index = mid_ext[rsas_pkg::INDEX_W-1:0];
          state_d       = rsas_pkg::ST_REPLY;
        end else begin
          // Keep the half that can hold the target.
          if (vl <= vm) begin
            if (vl <= target_q && target_q <= vm) begin
              high_d = mid_q - One;
            end else begin
              low_d = mid_q + One;
            end
          end else begin
            if (vm <= target_q && target_q <= vh) begin
              low_d = mid_q + One;
            end else begin
              high_d = mid_q - One;
            end
          end
          state_d = (low_d <= high_d) ? rsas_pkg::ST_PROBE : rsas_pkg::ST_REPLY;
        end
      end
      rsas_pkg::ST_REPLY: begin
        if (!out_valid_q || pop_i) begin
          out_d       = reply_q;
          out_valid_d = 1'b1;
          state_d     = rsas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsas_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsas_pkg::ST_IDLE;
      count_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mid_q    <= mid_d;
    target_q <= target_d;
    reply_q  <= reply_d;
    out_q    <= out_d;
  end

  // The element count never passes the store size.
  `RSAS_ASSERT(a_count_in_range, count_q <= CntW'(MaxElements))
  // Bounds stay inside the loaded array while a probe is compared.
  `RSAS_ASSERT_NEVER(a_bounds_out,
    (state_q == rsas_pkg::ST_CHECK) && (low_q < 0 || high_q >= $signed({1'b0, count_q})))
  // Both store copies return the same midpoint element.
  `RSAS_ASSERT(a_copies_agree, (state_q == rsas_pkg::ST_CHECK) |-> (rd_mid == rd_mid_copy))
  // A miss always reports index zero.
  `RSAS_ASSERT(a_miss_index, (out_valid_q && !out_q.found) |-> (out_q.index == '0))
  // A load finishes in the cycle it is taken.
  `RSAS_ASSERT(a_load_one_cycle,
    (state_q == rsas_pkg::ST_IDLE && cmd_pop_o && cmd_i.cmd.op != rsas_pkg::OP_SEARCH)
      |=> (state_q == rsas_pkg::ST_IDLE))

endmodule

// ===== rtl/rotated_sorted_array_search.sv =====
// Rotated sorted array search: top level joining the command front and the search back.
//
// Input channel: push / full carry in_item_i beats; a beat is taken when push
// is high and full is low. kind 0 appends element (restart begins a new array at
// position zero; appends beyond MAX_ELEMENTS are dropped), kind 1 searches for target.
// Result channel: empty / pop; the oldest result sits on out_item_o while empty
// is low and leaves when pop is high. Only searches give a result: found and the
// zero-based index of the hit, or found clear and index zero on a miss.
// A two-entry command queue sits in front, so beats are taken while the back works.
// A load is finished in the cycle the back takes it. A search is taken in IDLE, then
// runs for each probe a store read (PROBE) and a compare and bound update (CHECK),
// and posts its result in REPLY. The back takes no new command until the result
// is posted, so new commands wait in the command queue while a search runs.
// A waiting result does not block new beats; a second search result waits in the back
// until the result register is popped, and the command queue then fills up.
// Reset empties the array, the command queue and the result register.
module rotated_sorted_array_search #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  rsas_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output rsas_pkg::out_item_t out_item_o
);

  rsas_pkg::cmd_chan_t cmd;
  logic                cmd_pop;

  // Accept and classify input beats.
  rsas_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  // Execute loads and searches.
  rsas_back #(
    .MaxElements (MAX_ELEMENTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule
